// ----- sv/pressure_pid_with_feedforward_core_defines.svh -----
// ============================================================================
// pressure_pid_with_feedforward_core_defines.svh
// Assertion macros shared by the pressure controller RTL.
// ============================================================================
`ifndef PRESSURE_PID_WITH_FEEDFORWARD_CORE_DEFINES_SVH
`define PRESSURE_PID_WITH_FEEDFORWARD_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PPFF_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PPFF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ppff_pkg.sv -----
// ============================================================================
// ppff_pkg
// Types and constants of the pressure controller with flow feedforward.
// ============================================================================
package ppff_pkg;

    // Serial arithmetic unit widths
    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 35;
    localparam int DIV_N_W = 32;
    localparam int DIV_D_W = 17;

    // Configuration register indexes
    localparam logic [2:0] CFG_PROP_GAIN_BASE  = 3'd0;
    localparam logic [2:0] CFG_PROP_GAIN_BOOST = 3'd1;
    localparam logic [2:0] CFG_INTEGRAL_GAIN   = 3'd2;
    localparam logic [2:0] CFG_PRESSURE_DERIV  = 3'd3;
    localparam logic [2:0] CFG_FLOW_DERIV      = 3'd4;
    localparam logic [2:0] CFG_FILTER_ALPHA    = 3'd5;
    localparam logic [2:0] CFG_DRIVE_MIN       = 3'd6;
    localparam logic [2:0] CFG_DRIVE_MAX       = 3'd7;

    // Feedforward coefficients, Q.16
    localparam logic signed [63:0] FF_A0 = 64'sd226113;
    localparam logic signed [63:0] FF_A1 = 64'sd171199;
    localparam logic signed [63:0] FF_A2 = 64'sd1227720;
    localparam logic signed [63:0] FF_A3 = -64'sd327;
    localparam logic signed [63:0] FF_A4 = 64'sd205120;
    localparam logic signed [63:0] FF_A5 = 64'sd28306;

    // Flow derivative term limits, Q.16 percent
    localparam logic signed [63:0] UFD_LO = -64'sd983040;
    localparam logic signed [63:0] UFD_HI = 64'sd1638400;

    // Integral bound numerators: 30 << 24 and 10 << 24
    localparam logic [DIV_N_W-1:0] INT_POS_NUM = 32'd503316480;
    localparam logic [DIV_N_W-1:0] INT_NEG_NUM = 32'd167772160;

    localparam logic [DIV_D_W-1:0] FLOW_DIV  = 17'd15;
    localparam logic [DIV_D_W-1:0] STEP_DIV  = 17'd100;
    localparam logic signed [63:0] ROUND_HALF = 64'sd32768;

    typedef struct packed {
        logic                        start;
        logic signed [MUL_A_W-1:0]   a;
        logic signed [MUL_B_W-1:0]   b;
    } mul_req_t;

    typedef struct packed {
        logic                        busy;
        logic                        done;
        logic signed [MUL_A_W-1:0]   p;
    } mul_rsp_t;

    typedef struct packed {
        logic                        start;
        logic [DIV_N_W-1:0]          n;
        logic [DIV_D_W-1:0]          d;
    } div_req_t;

    typedef struct packed {
        logic                        busy;
        logic                        done;
        logic [DIV_N_W-1:0]          q;
        logic [DIV_D_W-1:0]          r;
    } div_rsp_t;

endpackage

// ----- sv/ppff_mul.sv -----
// ============================================================================
// ppff_mul
// Bit-serial signed multiplier: one multiplier bit per cycle, shift and add.
// ============================================================================
module ppff_mul
    import ppff_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    localparam int CW = $clog2(MUL_B_W);
    localparam logic [CW-1:0] LAST = CW'(MUL_B_W - 1);

    logic                      busy_reg;
    logic                      done_reg;
    logic [CW-1:0]             cnt_reg;
    logic signed [MUL_A_W-1:0] a_reg;
    logic signed [MUL_A_W-1:0] acc_reg;
    logic signed [MUL_B_W-1:0] b_reg;

    // Sequence the bit count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Add the shifted multiplicand; the sign bit weighs negative
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= (cnt_reg == LAST) ? acc_reg - a_reg : acc_reg + a_reg;
            end
            a_reg <= a_reg <<< 1;
            b_reg <= b_reg >>> 1;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

endmodule

// ----- sv/ppff_div.sv -----
// ============================================================================
// ppff_div
// Restoring unsigned divider: one quotient bit per cycle.
// ============================================================================
module ppff_div
    import ppff_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CW = $clog2(DIV_N_W);
    localparam logic [CW-1:0] LAST = CW'(DIV_N_W - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CW-1:0]       cnt_reg;
    logic [DIV_D_W-1:0]  rem_reg;
    logic [DIV_D_W-1:0]  d_reg;
    logic [DIV_N_W-1:0]  quo_reg;
    logic [DIV_D_W+1:0]  diff;

    // Trial subtract of the divisor from the shifted remainder
    assign diff = {1'b0, rem_reg, quo_reg[DIV_N_W-1]} - {2'b00, d_reg};

    // Sequence the bit count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Shift in one dividend bit, keep the difference when it does not borrow
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            d_reg   <= req.d;
            quo_reg <= req.n;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_D_W+1])
            begin
                rem_reg <= diff[DIV_D_W-1:0];
                quo_reg <= {quo_reg[DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DIV_D_W-2:0], quo_reg[DIV_N_W-1]};
                quo_reg <= {quo_reg[DIV_N_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.q    = quo_reg;
    assign rsp.r    = rem_reg;

endmodule

// ----- sv/pressure_pid_with_feedforward_core.sv -----
// ============================================================================
// pressure_pid_with_feedforward_core
// Pressure controller: quadratic flow feedforward, error-scaled proportional,
// filtered flow and pressure derivatives, integral with anti-windup.
// Each accepted request runs 18 serial multiplies and 4 serial divides,
// then the finish and output states, before the drive is valid.
// A new request is taken only once the sequencer is idle again.
// A finished drive waits in the output register while the next request runs.
// Reset (async, active low) loads register defaults, zeroes controller state.
// ============================================================================
`include "pressure_pid_with_feedforward_core_defines.svh"

module pressure_pid_with_feedforward_core
    import ppff_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         setpoint,
    input  logic signed [12:0] setpoint_offset,
    input  logic signed [15:0] pressure,
    input  logic signed [14:0] flow,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [9:0]         drive,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    // Operation steps
    localparam logic [4:0] OP_FQ      = 5'd0;
    localparam logic [4:0] OP_FF1     = 5'd1;
    localparam logic [4:0] OP_FF2     = 5'd2;
    localparam logic [4:0] OP_FF3A    = 5'd3;
    localparam logic [4:0] OP_FF3B    = 5'd4;
    localparam logic [4:0] OP_FF4A    = 5'd5;
    localparam logic [4:0] OP_FF4B    = 5'd6;
    localparam logic [4:0] OP_FF5A    = 5'd7;
    localparam logic [4:0] OP_FF5B    = 5'd8;
    localparam logic [4:0] OP_QLP_OLD = 5'd9;
    localparam logic [4:0] OP_QLP_RAW = 5'd10;
    localparam logic [4:0] OP_UFD     = 5'd11;
    localparam logic [4:0] OP_KP      = 5'd12;
    localparam logic [4:0] OP_UPP     = 5'd13;
    localparam logic [4:0] OP_PLP_OLD = 5'd14;
    localparam logic [4:0] OP_PLP_RAW = 5'd15;
    localparam logic [4:0] OP_UPD     = 5'd16;
    localparam logic [4:0] OP_UT      = 5'd17;
    localparam logic [4:0] OP_IHI     = 5'd18;
    localparam logic [4:0] OP_ILO     = 5'd19;
    localparam logic [4:0] OP_ISTEP   = 5'd20;
    localparam logic [4:0] OP_UPI     = 5'd21;

    // Configuration registers
    logic [15:0] prop_gain_base_reg;
    logic [15:0] prop_gain_boost_reg;
    logic [15:0] integral_gain_reg;
    logic [15:0] pressure_deriv_gain_reg;
    logic [15:0] flow_deriv_gain_reg;
    logic [15:0] filter_alpha_reg;
    logic [9:0]  drive_min_reg;
    logic [9:0]  drive_max_reg;

    // Controller state
    logic signed [15:0] prev_pressure_reg;
    logic signed [15:0] prev_flow_reg;
    logic signed [31:0] pressure_rate_reg;
    logic signed [31:0] flow_rate_reg;
    logic signed [31:0] error_integral_reg;

    // Sequencer and working registers
    logic [2:0]         state_reg;
    logic [4:0]         step_reg;
    logic               out_valid_reg;
    logic [9:0]         drive_reg;
    logic signed [17:0] sp_reg;
    logic signed [17:0] ep_reg;
    logic signed [15:0] p_reg;
    logic signed [14:0] q_reg;
    logic signed [16:0] dq_reg;
    logic signed [16:0] dp_reg;
    logic [18:0]        f_reg;
    logic signed [47:0] u_reg;
    logic signed [63:0] t_reg;
    logic               noint_reg;
    logic signed [31:0] ihi_reg;
    logic signed [31:0] ilo_reg;
    logic signed [33:0] integ_reg;

    // Unit interfaces
    mul_req_t mul_req;
    mul_rsp_t mul_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Derived values
    logic signed [63:0] prod;
    logic signed [63:0] prod_sh12;
    logic signed [63:0] ufd;
    logic [17:0]        aep;
    logic [16:0]        alpha_c;
    logic signed [63:0] dq64;
    logic signed [63:0] dp64;
    logic signed [63:0] raw_q;
    logic signed [63:0] raw_p;
    logic signed [63:0] lp_sum;
    logic signed [63:0] ut10;
    logic signed [63:0] u64;
    logic signed [63:0] tenths;
    logic signed [63:0] dmin64;
    logic signed [63:0] dmax64;
    logic signed [31:0] ei_clamp;
    logic               q_pos;
    logic               unit_done;
    logic               ki_zero;

    ppff_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    ppff_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign prod      = mul_rsp.p;
    assign prod_sh12 = prod >>> 12;
    assign unit_done = mul_rsp.done | div_rsp.done;
    assign ki_zero   = (integral_gain_reg == 16'd0);
    assign aep       = ep_reg[17] ? 18'(-ep_reg) : 18'(ep_reg);
    assign alpha_c   = 17'(17'h10000 - {1'b0, filter_alpha_reg});
    assign q_pos     = !q_reg[14] && (q_reg != 15'sd0);

    // Raw rates: flow difference times 6400, pressure difference times 1600
    assign dq64  = 64'(dq_reg);
    assign dp64  = 64'(dp_reg);
    assign raw_q = (dq64 <<< 12) + (dq64 <<< 11) + (dq64 <<< 8);
    assign raw_p = (dp64 <<< 10) + (dp64 <<< 9) + (dp64 <<< 6);
    assign lp_sum = t_reg + prod;

    // Flow derivative term limit
    always_comb
    begin
        if (prod_sh12 < UFD_LO)
            ufd = UFD_LO;
        else if (prod_sh12 > UFD_HI)
            ufd = UFD_HI;
        else
            ufd = prod_sh12;
    end

    // Tentative drive times ten, output scaling
    assign ut10   = (t_reg <<< 3) + (t_reg <<< 1);
    assign u64    = 64'(u_reg);
    assign tenths = t_reg >>> 16;
    assign dmin64 = 64'(drive_min_reg);
    assign dmax64 = 64'(drive_max_reg);

    // Integral bounds
    always_comb
    begin
        if (integ_reg < 34'(ilo_reg))
            ei_clamp = ilo_reg;
        else if (integ_reg > 34'(ihi_reg))
            ei_clamp = ihi_reg;
        else
            ei_clamp = integ_reg[31:0];
    end

    // Select unit operands for the current step
    always_comb
    begin
        mul_req = '0;
        div_req = '0;
        if (state_reg == ST_ISSUE)
        begin
            case (step_reg)
                OP_FQ:
                begin
                    div_req.start = 1'b1;
                    div_req.n     = q_pos ? {9'b0, q_reg, 8'b0} : '0;
                    div_req.d     = FLOW_DIV;
                end
                OP_IHI:
                begin
                    div_req.start = 1'b1;
                    div_req.n     = INT_POS_NUM;
                    div_req.d     = {1'b0, integral_gain_reg};
                end
                OP_ILO:
                begin
                    div_req.start = 1'b1;
                    div_req.n     = INT_NEG_NUM;
                    div_req.d     = {1'b0, integral_gain_reg};
                end
                OP_ISTEP:
                begin
                    div_req.start = 1'b1;
                    div_req.n     = {6'b0, aep, 8'b0};
                    div_req.d     = STEP_DIV;
                end
                default:
                begin
                    mul_req.start = 1'b1;
                    case (step_reg)
                        OP_FF1:
                        begin
                            mul_req.a = FF_A1;
                            mul_req.b = MUL_B_W'(sp_reg);
                        end
                        OP_FF2:
                        begin
                            mul_req.a = FF_A2;
                            mul_req.b = MUL_B_W'(f_reg);
                        end
                        OP_FF3A:
                        begin
                            mul_req.a = FF_A3;
                            mul_req.b = MUL_B_W'(sp_reg);
                        end
                        OP_FF3B:
                        begin
                            mul_req.a = t_reg;
                            mul_req.b = MUL_B_W'(sp_reg);
                        end
                        OP_FF4A:
                        begin
                            mul_req.a = FF_A4;
                            mul_req.b = MUL_B_W'(f_reg);
                        end
                        OP_FF4B:
                        begin
                            mul_req.a = t_reg;
                            mul_req.b = MUL_B_W'(f_reg);
                        end
                        OP_FF5A:
                        begin
                            mul_req.a = FF_A5;
                            mul_req.b = MUL_B_W'(sp_reg);
                        end
                        OP_FF5B:
                        begin
                            mul_req.a = t_reg;
                            mul_req.b = MUL_B_W'(f_reg);
                        end
                        OP_QLP_OLD:
                        begin
                            mul_req.a = MUL_A_W'(flow_rate_reg);
                            mul_req.b = MUL_B_W'(filter_alpha_reg);
                        end
                        OP_QLP_RAW:
                        begin
                            mul_req.a = raw_q;
                            mul_req.b = MUL_B_W'(alpha_c);
                        end
                        OP_UFD:
                        begin
                            mul_req.a = MUL_A_W'(flow_rate_reg);
                            mul_req.b = MUL_B_W'(flow_deriv_gain_reg);
                        end
                        OP_KP:
                        begin
                            mul_req.a = MUL_A_W'(aep);
                            mul_req.b = MUL_B_W'(prop_gain_boost_reg);
                        end
                        OP_UPP:
                        begin
                            mul_req.a = t_reg;
                            mul_req.b = MUL_B_W'(ep_reg);
                        end
                        OP_PLP_OLD:
                        begin
                            mul_req.a = MUL_A_W'(pressure_rate_reg);
                            mul_req.b = MUL_B_W'(filter_alpha_reg);
                        end
                        OP_PLP_RAW:
                        begin
                            mul_req.a = raw_p;
                            mul_req.b = MUL_B_W'(alpha_c);
                        end
                        OP_UPD:
                        begin
                            mul_req.a = MUL_A_W'(pressure_rate_reg);
                            mul_req.b = MUL_B_W'(pressure_deriv_gain_reg);
                        end
                        OP_UT:
                        begin
                            mul_req.a = MUL_A_W'(error_integral_reg);
                            mul_req.b = MUL_B_W'(integral_gain_reg);
                        end
                        default:
                        begin
                            mul_req.a = MUL_A_W'(ei_clamp);
                            mul_req.b = MUL_B_W'(integral_gain_reg);
                        end
                    endcase
                end
            endcase
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_base_reg      <= 16'd1536;
            prop_gain_boost_reg     <= 16'd256;
            integral_gain_reg       <= 16'd6400;
            pressure_deriv_gain_reg <= 16'd2949;
            flow_deriv_gain_reg     <= 16'd1311;
            filter_alpha_reg        <= 16'd61604;
            drive_min_reg           <= 10'd10;
            drive_max_reg           <= 10'd1000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PROP_GAIN_BASE:  prop_gain_base_reg      <= cfg_data;
                CFG_PROP_GAIN_BOOST: prop_gain_boost_reg     <= cfg_data;
                CFG_INTEGRAL_GAIN:   integral_gain_reg       <= cfg_data;
                CFG_PRESSURE_DERIV:  pressure_deriv_gain_reg <= cfg_data;
                CFG_FLOW_DERIV:      flow_deriv_gain_reg     <= cfg_data;
                CFG_FILTER_ALPHA:    filter_alpha_reg        <= cfg_data;
                CFG_DRIVE_MIN:       drive_min_reg           <= cfg_data[9:0];
                CFG_DRIVE_MAX:       drive_max_reg           <= cfg_data[9:0];
                default:             ;
            endcase
        end
    end

    // Sequence the steps, update controller state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            step_reg           <= OP_FQ;
            out_valid_reg      <= 1'b0;
            prev_pressure_reg  <= '0;
            prev_flow_reg      <= '0;
            pressure_rate_reg  <= '0;
            flow_rate_reg      <= '0;
            error_integral_reg <= '0;
        end
        else
        begin
            // Drop the result once taken, unless a new one replaces it
            if (out_valid_reg && !out_stall && (state_reg != ST_OUT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_ISSUE;
                        step_reg  <= OP_FQ;
                    end
                end
                ST_ISSUE:
                begin
                    state_reg <= ST_WAIT;
                    if (step_reg == OP_FQ)
                    begin
                        prev_flow_reg     <= 16'(q_reg);
                        prev_pressure_reg <= p_reg;
                    end
                    else if (step_reg == OP_UPI)
                    begin
                        error_integral_reg <= ei_clamp;
                    end
                end
                ST_WAIT:
                begin
                    if (unit_done)
                    begin
                        if (step_reg == OP_UPI)
                        begin
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            step_reg  <= step_reg + 5'd1;
                            state_reg <= ST_ISSUE;
                        end
                        if (step_reg == OP_QLP_RAW)
                            flow_rate_reg <= lp_sum[47:16];
                        if (step_reg == OP_PLP_RAW)
                            pressure_rate_reg <= lp_sum[47:16];
                    end
                end
                ST_FIN:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sp_reg <= $signed({2'b00, setpoint, 8'b0}) + 18'(setpoint_offset);
                    p_reg  <= pressure;
                    q_reg  <= flow;
                end
            end
            ST_ISSUE:
            begin
                if (step_reg == OP_FQ)
                begin
                    ep_reg <= sp_reg - 18'(p_reg);
                    dq_reg <= 17'(q_reg) - 17'(prev_flow_reg);
                    dp_reg <= 17'(p_reg) - 17'(prev_pressure_reg);
                end
                // Anti-windup test on the tentative drive
                if (step_reg == OP_IHI)
                begin
                    noint_reg <= ((ut10 >= (dmax64 <<< 16)) && (ep_reg > 18'sd0)) ||
                                 ((ut10 <= (dmin64 <<< 16)) && (ep_reg < 18'sd0));
                end
            end
            ST_WAIT:
            begin
                if (unit_done)
                begin
                    case (step_reg)
                        OP_FQ:      f_reg <= div_rsp.q[18:0];
                        OP_FF1:     u_reg <= 48'(FF_A0 + (prod >>> 8));
                        OP_FF2:     u_reg <= u_reg + 48'(prod >>> 16);
                        OP_FF3B:    u_reg <= u_reg + 48'(prod >>> 16);
                        OP_FF4B:    u_reg <= u_reg + 48'(prod >>> 32);
                        OP_FF5B:    u_reg <= u_reg + 48'(prod >>> 24);
                        OP_UFD:     u_reg <= u_reg + 48'(ufd);
                        OP_KP:      t_reg <= 64'({prop_gain_base_reg, 8'b0}) + prod;
                        OP_UPP:     u_reg <= u_reg + 48'(prod >>> 8);
                        OP_UPD:     u_reg <= u_reg - 48'(prod_sh12);
                        OP_UT:      t_reg <= u64 + (prod >>> 8);
                        OP_IHI:     ihi_reg <= ki_zero ? 32'sh7fffffff : $signed(div_rsp.q);
                        OP_ILO:     ilo_reg <= ki_zero ? 32'sh80000000 : 32'(-div_rsp.q);
                        OP_ISTEP:
                        begin
                            if (noint_reg)
                                integ_reg <= 34'(error_integral_reg);
                            else if (ep_reg[17])
                                integ_reg <= 34'(error_integral_reg) - 34'(div_rsp.q)
                                             - 34'(div_rsp.r != '0);
                            else
                                integ_reg <= 34'(error_integral_reg) + 34'(div_rsp.q);
                        end
                        OP_UPI:     u_reg <= u_reg + 48'(prod >>> 8);
                        default:    t_reg <= prod;
                    endcase
                end
            end
            ST_FIN:
            begin
                t_reg <= (u64 <<< 3) + (u64 <<< 1) + ROUND_HALF;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    if (tenths < dmin64)
                        drive_reg <= drive_min_reg;
                    else if (tenths > dmax64)
                        drive_reg <= drive_max_reg;
                    else
                        drive_reg <= tenths[9:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    // Checks on the shared arithmetic units and the sequencer
    `PPFF_ASSERT_IMPL(a_units_exclusive, clk, rst_n, mul_rsp.busy, !div_rsp.busy, "multiplier and divider busy together")
    `PPFF_ASSERT_IMPL(a_start_when_free, clk, rst_n, mul_req.start || div_req.start, !mul_rsp.busy && !div_rsp.busy, "unit started while busy")
    `PPFF_ASSERT_IMPL(a_idle_units_free, clk, rst_n, state_reg == ST_IDLE, !mul_rsp.busy && !div_rsp.busy, "unit busy while sequencer idle")
    `PPFF_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && !in_stall, state_reg == ST_ISSUE && step_reg == OP_FQ, "request did not start the sequence")

endmodule

// ----- verif/pressure_pid_with_feedforward_core_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pressure_pid_with_feedforward_core_checker
// Watches the request, drive and register-write ports of the pressure
// controller, computes the expected drive for every accepted request and
// compares each accepted drive against the oldest expected value.
// ----------------------------------------------------------------------------
module pressure_pid_with_feedforward_core_checker
    import ppff_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         setpoint,
    input  logic signed [12:0] setpoint_offset,
    input  logic signed [15:0] pressure,
    input  logic signed [14:0] flow,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [9:0]         drive,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 pending,
    output int                 errors
);

    localparam longint Q16 = 65536;

    // Register copies
    longint kp_base, kp_boost, ki_gain, kd_press, kd_flow, alpha, lim_min, lim_max;

    // Controller state copies
    int press_prev, flow_prev, press_rate, flow_rate, integ_acc;

    logic [9:0] drive_queue[$];

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q--;
        return q;
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return (x < lo) ? lo : (x > hi) ? hi : x;
    endfunction

    function automatic int smooth(int old, longint raw);
        longint v;
        v = (alpha * longint'(old) + (Q16 - alpha) * raw) >>> 16;
        return int'(v);
    endfunction

    // Advance the controller state by one sample and return the drive
    function automatic logic [9:0] next_drive(logic [7:0] sp8, logic signed [12:0] off,
                                              logic signed [15:0] pr,
                                              logic signed [14:0] fl);
        longint sp, p, q, ep, aep, f, uff, ufd, kp, upp, upd, ut, integ, ihi, ilo, upi;
        longint u, tenths;
        logic hold_hi, hold_lo;
        sp  = longint'(sp8) * 256 + longint'(off);
        p   = longint'(pr);
        q   = longint'(fl);
        ep  = sp - p;
        aep = (ep < 0) ? -ep : ep;

        // feedforward in setpoint and positive flow
        f   = (q > 0) ? floor_div(q * 256, 15) : 0;
        uff = FF_A0 + ((FF_A1 * sp) >>> 8) + ((FF_A2 * f) >>> 16)
            + ((FF_A3 * sp * sp) >>> 16) + ((FF_A4 * f * f) >>> 32)
            + ((FF_A5 * sp * f) >>> 24);

        // flow derivative
        flow_rate = smooth(flow_rate, (q - longint'(flow_prev)) * 100 * 64);
        flow_prev = int'(q);
        ufd = clip((kd_flow * longint'(flow_rate)) >>> 12, UFD_LO, UFD_HI);

        // proportional with error-scaled gain
        kp  = kp_base * 256 + aep * kp_boost;
        upp = (kp * ep) >>> 8;

        // pressure derivative
        press_rate = smooth(press_rate, (p - longint'(press_prev)) * 100 * 16);
        press_prev = int'(p);
        upd = -((kd_press * longint'(press_rate)) >>> 12);

        // integral, frozen while the tentative drive sits at the limit the error pushes toward
        ut = uff + ufd + upp + upd + ((ki_gain * longint'(integ_acc)) >>> 8);
        hold_hi = (ut * 10 >= lim_max * Q16) && ep > 0;
        hold_lo = (ut * 10 <= lim_min * Q16) && ep < 0;
        integ = integ_acc;
        if (!hold_hi && !hold_lo)
            integ += floor_div(ep * 256, 100);
        ihi = 64'sd2147483647;
        ilo = -64'sd2147483648;
        if (ki_gain != 0)
        begin
            ihi = (longint'(30) <<< 24) / ki_gain;
            ilo = -((longint'(10) <<< 24) / ki_gain);
        end
        integ_acc = int'(clip(integ, ilo, ihi));
        upi = (ki_gain * longint'(integ_acc)) >>> 8;

        u = uff + ufd + upp + upi + upd;
        tenths = (u * 10 + Q16 / 2) >>> 16;
        tenths = clip(tenths, lim_min, lim_max);
        return tenths[9:0];
    endfunction

    assign pending = drive_queue.size();

    // Track register writes, predict on requests, check drives
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_base    <= 1536;
            kp_boost   <= 256;
            ki_gain    <= 6400;
            kd_press   <= 2949;
            kd_flow    <= 1311;
            alpha      <= 61604;
            lim_min    <= 10;
            lim_max    <= 1000;
            press_prev = 0;
            flow_prev  = 0;
            press_rate = 0;
            flow_rate  = 0;
            integ_acc  = 0;
            errors     <= 0;
            drive_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PROP_GAIN_BASE:  kp_base  <= cfg_data;
                    CFG_PROP_GAIN_BOOST: kp_boost <= cfg_data;
                    CFG_INTEGRAL_GAIN:   ki_gain  <= cfg_data;
                    CFG_PRESSURE_DERIV:  kd_press <= cfg_data;
                    CFG_FLOW_DERIV:      kd_flow  <= cfg_data;
                    CFG_FILTER_ALPHA:    alpha    <= cfg_data;
                    CFG_DRIVE_MIN:       lim_min  <= cfg_data[9:0];
                    CFG_DRIVE_MAX:       lim_max  <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                drive_queue.push_back(next_drive(setpoint, setpoint_offset, pressure, flow));
            if (out_valid && !out_stall)
            begin
                if (drive_queue.size() == 0)
                begin
                    $error("drive: no request outstanding, actual %0d", drive);
                    errors <= errors + 1;
                end
                else
                begin
                    logic [9:0] exp_drive;
                    exp_drive = drive_queue.pop_front();
                    if (drive !== exp_drive)
                    begin
                        $error("drive: expected %0d, actual %0d", exp_drive, drive);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- verif/pressure_pid_with_feedforward_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pressure_pid_with_feedforward_core_test
// Drives the pressure controller through several register settings with
// directed corner samples and random pressure traces, idling both sides at
// random; a side checker predicts and compares every drive.
// ----------------------------------------------------------------------------
module pressure_pid_with_feedforward_core_test;
    import ppff_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int RAND_PER_PHASE = 100;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         setpoint;
    logic signed [12:0] setpoint_offset;
    logic signed [15:0] pressure;
    logic signed [14:0] flow;
    logic               out_valid;
    logic               out_stall;
    logic [9:0]         drive;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    int                 pending;
    int                 errors;
    int                 cycles;
    logic               quiet;
    int                 stall_left;

    pressure_pid_with_feedforward_core i_dut (.*);

    pressure_pid_with_feedforward_core_checker i_checker (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int gap_length();
        if (quiet)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 300);
        return $urandom_range(0, 3);
    endfunction

    // Random drive-side stall, with quiet stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else
        begin
            stall_left <= gap_length();
            out_stall  <= !out_stall && !quiet;
        end
    end

    task automatic send(logic [7:0] sp, logic [12:0] off, logic [15:0] pr, logic [14:0] fl);
        int gap;
        in_valid        <= 1'b1;
        setpoint        <= sp;
        setpoint_offset <= off;
        pressure        <= pr;
        flow            <= fl;
        do
            @(posedge clk);
        while (in_stall);
        gap = gap_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Drain all requests, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Mostly a breathing-like trace around the setpoint, some pure noise
    task automatic random_phase(int count);
        logic [7:0] sp;
        int pr;
        int fl;
        sp = 8'($urandom_range(0, 40));
        pr = sp * 256;
        fl = 0;
        for (int k = 0; k < count; k++)
        begin
            if (k % 30 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
            begin
                send(8'($urandom), 13'($urandom), 16'($urandom), 15'($urandom));
            end
            else
            begin
                if ($urandom_range(0, 15) == 0)
                    sp = 8'($urandom_range(0, 60));
                pr = pr + $signed($urandom_range(0, 1200)) - 600;
                if (pr > 32767)
                    pr = 32767;
                if (pr < -32768)
                    pr = -32768;
                fl = fl + $signed($urandom_range(0, 800)) - 400;
                if (fl > 16383)
                    fl = 16383;
                if (fl < -16384)
                    fl = -16384;
                send(sp, 13'($urandom_range(0, 1023) - 512), 16'(pr), 15'(fl));
            end
        end
        quiet = 1'b0;
    endtask

    task automatic directed_phase();
        // field extremes
        send(8'd0, 13'h1000, 16'h8000, 15'h4000);
        send(8'd255, 13'h0FFF, 16'h7FFF, 15'h3FFF);
        send(8'd0, 13'h0000, 16'h0000, 15'h0000);
        send(8'd255, 13'h1000, 16'h8000, 15'h3FFF);
        send(8'd0, 13'h0FFF, 16'h7FFF, 15'h4000);
        // hold a large positive error: drive at the top, integral frozen
        repeat (5) send(8'd255, 13'h0FFF, 16'h8000, 15'h3FFF);
        // hold a large negative error: drive at the bottom
        repeat (5) send(8'd0, 13'h1000, 16'h7FFF, 15'h4000);
        // small steady error drives the integral into its bound
        repeat (6) send(8'd20, 13'h0000, 16'd4000, 15'd200);
        send(8'd20, 13'h0000, 16'd5120, 15'd0);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        setpoint        = '0;
        setpoint_offset = '0;
        pressure        = '0;
        flow            = '0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_PROP_GAIN_BASE;
        cfg_data        = '0;
        quiet           = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults
        directed_phase();
        random_phase(RAND_PER_PHASE);
        drain();

        // Maximum gains, no filtering, limits 0 to 1000
        write_reg(CFG_PROP_GAIN_BASE, 16'hFFFF);
        write_reg(CFG_PROP_GAIN_BOOST, 16'hFFFF);
        write_reg(CFG_INTEGRAL_GAIN, 16'hFFFF);
        write_reg(CFG_PRESSURE_DERIV, 16'hFFFF);
        write_reg(CFG_FLOW_DERIV, 16'hFFFF);
        write_reg(CFG_FILTER_ALPHA, 16'h0000);
        write_reg(CFG_DRIVE_MIN, 16'd0);
        write_reg(CFG_DRIVE_MAX, 16'd1000);
        directed_phase();
        random_phase(RAND_PER_PHASE);
        drain();

        // Zero gains, heavy filtering, integral free to saturate
        write_reg(CFG_PROP_GAIN_BASE, 16'h0000);
        write_reg(CFG_PROP_GAIN_BOOST, 16'h0000);
        write_reg(CFG_INTEGRAL_GAIN, 16'h0000);
        write_reg(CFG_PRESSURE_DERIV, 16'h0000);
        write_reg(CFG_FLOW_DERIV, 16'h0000);
        write_reg(CFG_FILTER_ALPHA, 16'hFFFF);
        random_phase(RAND_PER_PHASE / 2);
        drain();

        // Inverted limits, smallest nonzero integral gain
        write_reg(CFG_PROP_GAIN_BASE, 16'd1536);
        write_reg(CFG_INTEGRAL_GAIN, 16'd1);
        write_reg(CFG_DRIVE_MIN, 16'd900);
        write_reg(CFG_DRIVE_MAX, 16'd100);
        random_phase(RAND_PER_PHASE / 2);
        drain();

        // Random settings
        for (int r = 0; r < 2; r++)
        begin
            write_reg(CFG_PROP_GAIN_BASE, 16'($urandom_range(0, 4095)));
            write_reg(CFG_PROP_GAIN_BOOST, 16'($urandom_range(0, 2047)));
            write_reg(CFG_INTEGRAL_GAIN, 16'($urandom));
            write_reg(CFG_PRESSURE_DERIV, 16'($urandom));
            write_reg(CFG_FLOW_DERIV, 16'($urandom));
            write_reg(CFG_FILTER_ALPHA, 16'($urandom));
            write_reg(CFG_DRIVE_MIN, 16'($urandom_range(0, 400)));
            write_reg(CFG_DRIVE_MAX, 16'($urandom_range(500, 1000)));
            random_phase(RAND_PER_PHASE / 2);
            drain();
        end

        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
